### rtl/bc_pkg.sv
// ----------------------------------------------------------------------------
// bc_pkg
// shared types and defaults for the binomial coefficient unit
// ----------------------------------------------------------------------------
package bc_pkg;

    localparam int DEF_INPUT_BITS  = 8;
    localparam int DEF_RESULT_BITS = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEST,
        ST_MUL,
        ST_DIV,
        ST_UPD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic mul_start;
        logic mul_step;
        logic div_start;
        logic div_step;
        logic update;
    } t_dp_cmd;

    typedef struct packed {
        logic fin;
        logic cnt_zero;
    } t_dp_status;

endpackage

### rtl/bc_datapath.sv
// ----------------------------------------------------------------------------
// bc_datapath
// running value, shift-add multiplier and restoring divider for C(n,k)
// ----------------------------------------------------------------------------
module bc_datapath #(
    parameter int INPUT_BITS  = bc_pkg::DEF_INPUT_BITS,
    parameter int RESULT_BITS = bc_pkg::DEF_RESULT_BITS
) (
    input  logic                   i_clk,
    input  logic [INPUT_BITS-1:0]  i_total,
    input  logic [INPUT_BITS-1:0]  i_choose,
    input  bc_pkg::t_dp_cmd        i_cmd,
    output bc_pkg::t_dp_status     o_status,
    output logic [RESULT_BITS-1:0] o_result,
    output logic                   o_ovf
);
    import bc_pkg::*;

    localparam int PW = RESULT_BITS + INPUT_BITS;
    localparam int CW = $clog2(PW);

    logic [INPUT_BITS-1:0]  r_n, r_k, r_i, r_mul;
    logic [INPUT_BITS-1:0]  r_rem;
    logic [RESULT_BITS-1:0] r_c;
    logic [PW-1:0]          r_acc;
    logic [CW-1:0]          r_bit;
    logic                   r_ovf;

    logic [INPUT_BITS-1:0]  nk, kk;
    logic [INPUT_BITS:0]    rem_sh;
    logic [INPUT_BITS:0]    diff;
    logic                   q_bit;
    logic [PW-1:0]          mul_sum;

    assign nk      = i_total - i_choose;
    assign kk      = (i_choose > nk) ? nk : i_choose;
    assign rem_sh  = {r_rem, r_acc[PW-1]};
    assign diff    = rem_sh - {1'b0, r_i};
    assign q_bit   = (rem_sh >= {1'b0, r_i});
    assign mul_sum = {r_acc[PW-2:0], 1'b0}
                   + (r_mul[INPUT_BITS-1] ? PW'(r_c) : PW'(0));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n   <= i_total;
            r_i   <= INPUT_BITS'(2);
            r_ovf <= 1'b0;
            if (i_choose > i_total) begin
                r_c <= '0;
                r_k <= '0;
            end else if (kk == '0) begin
                r_c <= RESULT_BITS'(1);
                r_k <= '0;
            end else begin
                r_c <= RESULT_BITS'(i_total);
                r_k <= kk;
            end
        end

        if (i_cmd.mul_start) begin
            r_acc <= '0;
            r_mul <= r_n - r_i + INPUT_BITS'(1);
        end else if (i_cmd.mul_step) begin
            r_acc <= mul_sum;
            r_mul <= {r_mul[INPUT_BITS-2:0], 1'b0};
        end else if (i_cmd.div_step) begin
            r_acc <= {r_acc[PW-2:0], q_bit};
            r_rem <= q_bit ? diff[INPUT_BITS-1:0] : rem_sh[INPUT_BITS-1:0];
        end

        if (i_cmd.div_start) begin
            r_rem <= '0;
        end

        if (i_cmd.mul_start) begin
            r_bit <= CW'(INPUT_BITS - 1);
        end else if (i_cmd.div_start) begin
            r_bit <= CW'(PW - 1);
        end else if (i_cmd.mul_step || i_cmd.div_step) begin
            r_bit <= r_bit - CW'(1);
        end

        // quotient above result width means saturation
        if (i_cmd.update) begin
            r_i <= r_i + INPUT_BITS'(1);
            if (r_acc[PW-1:RESULT_BITS] != '0) begin
                r_c   <= '1;
                r_ovf <= 1'b1;
            end else begin
                r_c <= r_acc[RESULT_BITS-1:0];
            end
        end
    end

    assign o_status.fin      = r_ovf || (r_i > r_k);
    assign o_status.cnt_zero = (r_bit == '0);
    assign o_result          = r_c;
    assign o_ovf             = r_ovf;

endmodule

### rtl/bc_ctrl.sv
// ----------------------------------------------------------------------------
// bc_ctrl
// sequencer for the multiply then exact divide loop
// ----------------------------------------------------------------------------
module bc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_out_free,
    input  bc_pkg::t_dp_status i_status,
    output logic               o_in_ready,
    output logic               o_out_load,
    output bc_pkg::t_dp_cmd    o_cmd
);
    import bc_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_TEST;
            end
            ST_TEST: begin
                n_state = i_status.fin ? ST_DONE : ST_MUL;
            end
            ST_MUL: begin
                if (i_status.cnt_zero) n_state = ST_DIV;
            end
            ST_DIV: begin
                if (i_status.cnt_zero) n_state = ST_UPD;
            end
            ST_UPD: begin
                n_state = ST_TEST;
            end
            ST_DONE: begin
                if (i_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        o_out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_TEST: begin
                o_cmd.mul_start = !i_status.fin;
            end
            ST_MUL: begin
                o_cmd.mul_step  = 1'b1;
                o_cmd.div_start = i_status.cnt_zero;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            ST_UPD: begin
                o_cmd.update = 1'b1;
            end
            ST_DONE: begin
                o_out_load = i_out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

### rtl/binomial_coefficient.sv
// ----------------------------------------------------------------------------
// binomial_coefficient
// computes C(n,k) with saturation to all ones and an overflow flag
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one word {choose_count, total_count}; m_axis returns one
//   word per input with combinations in tdata and overflow in tuser.
//   k is folded to min(k, n-k); k > n gives 0, a folded k of 0 gives 1.
//   each loop step i = 2..k is a shift-add multiply by n-i+1, then a
//   restoring divide by i, then the update and test states of the
//   sequencer; the loop ends early when the value saturates. one item is
//   worked at a time, the sequencer being the limit, and the next word can
//   be accepted in the cycle after the result is loaded.
//   a finished result sits in the output register, so the next word is
//   accepted while the receiver stalls; a second result then waits in the
//   sequencer until the output register drains.
//   reset (synchronous, active low) returns to idle and drops m_axis_tvalid.
// ----------------------------------------------------------------------------
module binomial_coefficient #(
    parameter int INPUT_BITS  = bc_pkg::DEF_INPUT_BITS,
    parameter int RESULT_BITS = bc_pkg::DEF_RESULT_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // total_count, choose_count
    input  logic [((2*INPUT_BITS+7)/8)*8-1:0]     s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // combinations
    output logic [((RESULT_BITS+7)/8)*8-1:0]      m_axis_tdata,
    // overflow
    output logic                                  m_axis_tuser
);
    import bc_pkg::*;

    localparam int OUT_W = ((RESULT_BITS + 7) / 8) * 8;

    t_dp_cmd                cmd;
    t_dp_status             status;
    logic                   out_load;
    logic                   out_free;
    logic [RESULT_BITS-1:0] dp_result;
    logic                   dp_ovf;

    logic                   r_out_valid;
    logic [RESULT_BITS-1:0] r_out_data;
    logic                   r_out_ovf;

    assign out_free = !r_out_valid || m_axis_tready;

    bc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_out_free (out_free),
        .i_status   (status),
        .o_in_ready (s_axis_tready),
        .o_out_load (out_load),
        .o_cmd      (cmd)
    );

    bc_datapath #(
        .INPUT_BITS  (INPUT_BITS),
        .RESULT_BITS (RESULT_BITS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_total  (s_axis_tdata[INPUT_BITS-1:0]),
        .i_choose (s_axis_tdata[2*INPUT_BITS-1:INPUT_BITS]),
        .i_cmd    (cmd),
        .o_status (status),
        .o_result (dp_result),
        .o_ovf    (dp_ovf)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= dp_result;
            r_out_ovf  <= dp_ovf;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'(r_out_data);
    assign m_axis_tuser  = r_out_ovf;

`ifndef SYNTHESIS
    a_sat_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_ovf) |-> (r_out_data == {RESULT_BITS{1'b1}}))
        else $error("overflow flagged without saturated value");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second word taken while busy");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_valid || m_axis_tready))
        else $error("output register overwritten before taken");

    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> !s_axis_tready)
        else $error("result loaded while idle");
`endif

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the n-choose-k unit
// ----------------------------------------------------------------------------
// drives {choose_count, total_count} words into s_axis and predicts each
// C(n,k) with a double-width multiply and exact divide, saturating above the
// result width. results on m_axis are compared in order with the prediction.
// a directed set covers the corner values, then random words follow with
// random gaps and stalls on both sides, quiet at the end.
// ----------------------------------------------------------------------------
module testbench;

    localparam int NB = bc_pkg::DEF_INPUT_BITS;
    localparam int RB = bc_pkg::DEF_RESULT_BITS;
    localparam int TW = ((2*NB+7)/8)*8;
    localparam int RW = ((RB+7)/8)*8;

    typedef struct {
        logic [NB-1:0] total;
        logic [NB-1:0] chosen;
        logic [RB-1:0] combos;
        logic          saturated;
    } t_choose_result;

    class choose_scoreboard;
        t_choose_result pending_results[$];
        int mismatches;
        int words_seen;
        int saturated_seen;
        int above_total;

        static function t_choose_result choose_predict(logic [NB-1:0] n, logic [NB-1:0] k_in);
            t_choose_result r;
            logic [2*RB-1:0] acc;
            logic [NB-1:0]   k;
            int i;
            r.total     = n;
            r.chosen    = k_in;
            r.combos    = '0;
            r.saturated = 1'b0;
            if (k_in > n) begin
                return r;
            end
            k = (k_in > n - k_in) ? n - k_in : k_in;
            if (k == 0) begin
                r.combos = RB'(1);
                return r;
            end
            acc = (2*RB)'(n);
            for (i = 2; i <= int'(k) && !r.saturated; i++) begin
                acc = acc * (2*RB)'(n - NB'(i) + NB'(1)) / (2*RB)'(i);
                if (acc > {RB{1'b1}}) begin
                    r.saturated = 1'b1;
                end
            end
            r.combos = r.saturated ? {RB{1'b1}} : acc[RB-1:0];
            return r;
        endfunction

        function void note_word(logic [NB-1:0] n, logic [NB-1:0] k);
            t_choose_result r;
            r = choose_predict(n, k);
            if (r.saturated) saturated_seen++;
            if (k > n) above_total++;
            words_seen++;
            pending_results.push_back(r);
        endfunction

        function void check_word(logic [RW-1:0] data, logic ovf);
            t_choose_result r;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: combinations %0h overflow %0b", data, ovf);
                return;
            end
            r = pending_results.pop_front();
            if (data[RB-1:0] !== r.combos || ovf !== r.saturated) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("C(%0d,%0d): expected %0h ovf %0b, got %0h ovf %0b",
                             r.total, r.chosen, r.combos, r.saturated, data[RB-1:0], ovf);
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic          i_clk;
    logic          i_rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    // total_count, choose_count
    logic [TW-1:0] s_axis_tdata;
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    // combinations
    logic [RW-1:0] m_axis_tdata;
    // overflow
    logic          m_axis_tuser;

    bit idle_on = 1'b1;
    choose_scoreboard board = new();

    binomial_coefficient u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #40ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // receiver stalls
    initial begin
        m_axis_tready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_word(m_axis_tdata, m_axis_tuser);
    end

    task automatic send_word(input logic [NB-1:0] n, input logic [NB-1:0] k);
        if (idle_on && $urandom_range(0, 2) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TW'({k, n});
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_word(n, k);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        logic [NB-1:0] n;
        logic [NB-1:0] k;
        int sel;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_rst_n       <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corners: empty and full choices, k above n, largest fit, first saturation
        send_word(8'd0,   8'd0);
        send_word(8'd255, 8'd0);
        send_word(8'd255, 8'd255);
        send_word(8'd0,   8'd255);
        send_word(8'd5,   8'd7);
        send_word(8'd255, 8'd254);
        send_word(8'd254, 8'd1);
        send_word(8'd1,   8'd1);
        send_word(8'd128, 8'd128);
        send_word(8'd67,  8'd33);
        send_word(8'd67,  8'd34);
        send_word(8'd68,  8'd34);
        send_word(8'd66,  8'd33);
        send_word(8'd64,  8'd32);
        send_word(8'd10,  8'd5);
        send_word(8'd170, 8'd85);
        send_word(8'd85,  8'd170);
        send_word(8'd255, 8'd127);
        send_word(8'd255, 8'd128);
        send_word(8'd200, 8'd100);
        send_word(8'd2,   8'd1);

        // hold off until the unit has delivered everything
        drain_results();

        for (int w = 0; w < 80; w++) begin
            if (w == 64) idle_on = 1'b0;
            sel = $urandom_range(0, 9);
            if (sel < 2) begin
                n = NB'($urandom_range(0, 255));
                k = NB'($urandom_range(0, 255));
            end else if (sel < 7) begin
                n = NB'($urandom_range(0, 70));
                k = NB'($urandom_range(0, n));
            end else begin
                n = NB'($urandom_range(0, 255));
                k = NB'($urandom_range(0, n));
            end
            send_word(n, k);
        end

        drain_results();
        repeat (100) @(posedge i_clk);

        if (board.pending() != 0) begin
            board.mismatches += board.pending();
            $display("%0d results never arrived", board.pending());
        end
        $display("sent %0d words: %0d saturated, %0d with k above n; %0d mismatches",
                 board.words_seen, board.saturated_seen, board.above_total, board.mismatches);
        if (board.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
